// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared immediate-implication and next-cycle-implication checks for the
// euclidean distance block. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ED_ASSERT_IMP(lbl, clk, rst, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ED_ASSERT_NXT(lbl, clk, rst, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error(msg);
`else
`define ED_ASSERT_IMP(lbl, clk, rst, ant, con, msg)
`define ED_ASSERT_NXT(lbl, clk, rst, ant, con, msg)
`endif

`endif

// ----- hw/rtl/ed_pkg.sv -----
// ----------------------------------------------------------------------------
// Euclidean distance package
// Field widths and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package ed_pkg;

  // Field and internal widths.
  localparam int ELEM_W = 16;
  localparam int MAG_W  = 16;
  localparam int SQ_W   = 32;
  localparam int ACC_W  = 46;
  localparam int DIST_W = 23;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // an input transfer happens this cycle
    logic start_root;  // capture the final sum and start the square root
    logic load_out;    // move the finished result into the output register
  } ed_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic final_valid; // the last pair of a vector is at the accumulator
    logic root_busy;   // the square root unit is iterating
    logic out_full;    // the output register holds an untaken result
  } ed_status_t;

endpackage

// ----- hw/rtl/ed_isqrt.sv -----
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 46-bit value by the bitwise method, one result bit
// per cycle.
// ----------------------------------------------------------------------------
module ed_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ed_pkg::ACC_W-1:0]  value,
  output logic                      busy,
  output logic [ed_pkg::DIST_W-1:0] root
);

  localparam int W = ed_pkg::ACC_W;

  logic [W-1:0] rem;
  logic [W-1:0] acc_root;
  logic [W-1:0] bit_mask;
  logic [W:0]   trial;
  logic         fits;

  // Trial subtraction of the current root plus the weight under test.
  assign trial = {1'b0, acc_root} + {1'b0, bit_mask};
  assign fits  = {1'b0, rem} >= trial;

  // Control: busy until the weight of one has been tried.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bit_mask[0]) begin
      busy <= 1'b0;
    end
  end

  // Datapath: one step of the bitwise method per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= value;
      acc_root <= '0;
      bit_mask <= W'(1) << (W - 2);
    end else if (busy) begin
      if (fits) begin
        rem      <= rem - trial[W-1:0];
        acc_root <= (acc_root >> 1) + bit_mask;
      end else begin
        acc_root <= acc_root >> 1;
      end
      bit_mask <= bit_mask >> 2;
    end
  end

  assign root = acc_root[ed_pkg::DIST_W-1:0];

endmodule

// ----- hw/rtl/ed_datapath.sv -----
// ----------------------------------------------------------------------------
// Euclidean distance datapath
// Difference magnitude, square and saturating accumulation in a three-stage
// pipeline, the square root unit and the output register.
// ----------------------------------------------------------------------------
module ed_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  ed_pkg::ed_cmd_t                  cmd,
  output ed_pkg::ed_status_t               status,
  input  logic signed [ed_pkg::ELEM_W-1:0] elem_a,
  input  logic signed [ed_pkg::ELEM_W-1:0] elem_b,
  input  logic                             last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ed_pkg::DIST_W-1:0]        distance,
  output logic [ed_pkg::ACC_W-1:0]         sum_squares,
  output logic                             overflowed
);

  localparam int AW = ed_pkg::ACC_W;

  logic signed [ed_pkg::ELEM_W:0] diff;
  logic [ed_pkg::ELEM_W:0]        diff_abs;
  logic [ed_pkg::MAG_W-1:0]       mag;
  logic                           mag_valid;
  logic                           mag_last;
  logic [ed_pkg::SQ_W-1:0]        sq;
  logic                           sq_valid;
  logic                           sq_last;
  logic [AW-1:0]                  acc;
  logic                           sat;
  logic [AW:0]                    sum_wide;
  logic [AW-1:0]                  acc_next;
  logic                           sat_next;
  logic [AW-1:0]                  fin_sum;
  logic                           fin_sat;
  logic                           root_busy;
  logic [ed_pkg::DIST_W-1:0]      root;

  // Stage one: exact difference and its magnitude, which fits in 16 bits.
  assign diff     = {elem_a[ed_pkg::ELEM_W-1], elem_a} - {elem_b[ed_pkg::ELEM_W-1], elem_b};
  assign diff_abs = diff[ed_pkg::ELEM_W] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mag      <= diff_abs[ed_pkg::MAG_W-1:0];
      mag_last <= last;
    end
    sq      <= ed_pkg::SQ_W'(mag) * ed_pkg::SQ_W'(mag);
    sq_last <= mag_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
      sq_valid  <= 1'b0;
    end else begin
      mag_valid <= cmd.take;
      sq_valid  <= mag_valid;
    end
  end

  // Stage three: saturating accumulation.
  assign sum_wide = {1'b0, acc} + (AW + 1)'(sq);
  assign acc_next = sum_wide[AW] ? {AW{1'b1}} : sum_wide[AW-1:0];
  assign sat_next = sat | sum_wide[AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      sat <= 1'b0;
    end else if (cmd.start_root) begin
      acc <= '0;
      sat <= 1'b0;
    end else if (sq_valid) begin
      acc <= acc_next;
      sat <= sat_next;
    end
  end

  // Final sum and flag are held while the root is worked out.
  always_ff @(posedge clk) begin
    if (cmd.start_root) begin
      fin_sum <= acc_next;
      fin_sat <= sat_next;
    end
  end

  ed_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_root),
    .value (acc_next),
    .busy  (root_busy),
    .root  (root)
  );

  // Output register: valid holds until the result transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      distance    <= root;
      sum_squares <= fin_sum;
      overflowed  <= fin_sat;
    end
  end

  assign status.final_valid = sq_valid & sq_last;
  assign status.root_busy   = root_busy;
  assign status.out_full    = out_valid;

endmodule

// ----- hw/rtl/ed_ctrl.sv -----
// ----------------------------------------------------------------------------
// Euclidean distance controller
// Sequences streaming, pipeline drain, square root and result hand-over.
// ----------------------------------------------------------------------------
module ed_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               last,
  input  ed_pkg::ed_status_t status,
  output ed_pkg::ed_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_RUN   = 4'b0001,
    ST_DRAIN = 4'b0010,
    ST_ROOT  = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Commands follow directly from the state and the datapath status.
  assign in_ready       = (state == ST_RUN);
  assign cmd.take       = in_valid & in_ready;
  assign cmd.start_root = (state == ST_DRAIN) & status.final_valid;
  assign cmd.load_out   = (state == ST_LOAD) & ~status.out_full;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN:   if (cmd.take && last) state_next = ST_DRAIN;
      ST_DRAIN: if (status.final_valid) state_next = ST_ROOT;
      ST_ROOT:  if (!status.root_busy) state_next = ST_LOAD;
      ST_LOAD:  if (!status.out_full) state_next = ST_RUN;
      default:  state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/euclidean_distance.sv -----
// ----------------------------------------------------------------------------
// Euclidean distance
// Accumulates squared differences of Q1.15 element pairs and, on the last
// pair, gives the floor square root of the sum with the sum and its flag.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   elem_a, elem_b, last
//   output    out_valid / out_ready distance, sum_squares, overflowed
//
// Pairs not marked last are taken one per cycle into a three-stage
// multiply-accumulate pipeline. After the last pair, input stalls through the
// drain state, until that pair reaches the accumulator, the root state, until
// the square root unit is seen to finish, and the load state, in which the
// output register is loaded. A result still held in the output register
// stretches the stall. Reset is synchronous and clears the sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euclidean_distance (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ed_pkg::ELEM_W-1:0] elem_a,
  input  logic signed [ed_pkg::ELEM_W-1:0] elem_b,
  input  logic                             last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ed_pkg::DIST_W-1:0]        distance,
  output logic [ed_pkg::ACC_W-1:0]         sum_squares,
  output logic                             overflowed
);

  ed_pkg::ed_cmd_t    cmd;
  ed_pkg::ed_status_t status;

  // Controller.
  ed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .last     (last),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  ed_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .elem_a      (elem_a),
    .elem_b      (elem_b),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .distance    (distance),
    .sum_squares (sum_squares),
    .overflowed  (overflowed)
  );

  // No input is taken while the square root unit iterates.
  `ED_ASSERT_IMP(a_no_take_in_root, clk, rst, status.root_busy, !in_ready, "input taken during root")
  // A transfer of a last pair stops further input in the next cycle.
  `ED_ASSERT_NXT(a_last_stalls, clk, rst, in_valid && in_ready && last, !in_ready, "input after last")
  // The root starts only when the final pair has reached the accumulator.
  `ED_ASSERT_IMP(a_start_final, clk, rst, cmd.start_root, status.final_valid, "early root start")
  // A result is loaded only into an empty output register, with the root unit idle.
  `ED_ASSERT_IMP(a_load_empty, clk, rst, cmd.load_out, !out_valid && !status.root_busy, "bad load")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Euclidean distance testbench
// Streams element pairs into the block and checks every result against
// a local model, or the table for typed rows. The model holds the running sum
// of squares and the sticky saturation flag, and takes the floor square root
// at the end of each vector. A short table of directed vectors comes first.
// It covers field extremes, one-pair vectors, a vector of the full rated
// length, a longer one, a sum that lands exactly on its ceiling and one that
// saturates. Random vectors follow. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module testbench;

  localparam int ELEM_W = ed_pkg::ELEM_W;
  localparam int ACC_W  = ed_pkg::ACC_W;
  localparam int DIST_W = ed_pkg::DIST_W;

  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;
  localparam logic [ACC_W-1:0]  SUM_CEILING  = {ACC_W{1'b1}};
  localparam logic [DIST_W-1:0] ROOT_CEILING = {DIST_W{1'b1}};

  localparam int RANDOM_PAIRS = 1300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;

  // One vector result as it leaves the block.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [ACC_W-1:0]  sum_squares;
    logic              overflowed;
  } dist_result_t;

  // One table row: a pair repeated reps times. last goes out on the final
  // repeat only, and typed marks a row whose result is written out in full.
  typedef struct packed {
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    logic [15:0]              reps;
    logic                     fin;
    logic                     typed;
    logic [DIST_W-1:0]        exp_distance;
    logic [ACC_W-1:0]         exp_sum;
    logic                     exp_flag;
  } pair_row_t;

  localparam int NUM_ROWS = 22;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ELEM_W-1:0] elem_a = '0;
  logic signed [ELEM_W-1:0] elem_b = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIST_W-1:0] distance;
  logic [ACC_W-1:0]  sum_squares;
  logic              overflowed;

  // Model state: running sum of squared differences and its sticky flag.
  logic [ACC_W-1:0] sum_model = '0;
  logic             saturated_model = 1'b0;

  dist_result_t pending_results[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit quiet_mode = 1'b0;

  // Directed vectors. The ceiling vector is 16384 maximal squares plus
  // 46340^2 + 267^2 + 19^2 + 3^2 + 2^2, which lands exactly on 2^46 - 1.
  pair_row_t directed_rows [NUM_ROWS] = '{
    '{16'sd0,      16'sd0,      16'd1,     1'b1, 1'b1, 23'd0,     46'd0,          1'b0},
    '{ELEM_MAX,    ELEM_MIN,    16'd1,     1'b1, 1'b1, 23'd65535, 46'd4294836225, 1'b0},
    '{ELEM_MIN,    ELEM_MAX,    16'd1,     1'b1, 1'b1, 23'd65535, 46'd4294836225, 1'b0},
    '{ELEM_MIN,    ELEM_MIN,    16'd1,     1'b1, 1'b1, 23'd0,     46'd0,          1'b0},
    '{ELEM_MAX,    ELEM_MAX,    16'd1,     1'b1, 1'b1, 23'd0,     46'd0,          1'b0},
    '{16'sd1,      16'sd0,      16'd1,     1'b1, 1'b1, 23'd1,     46'd1,          1'b0},
    '{16'sd100,    -16'sd200,   16'd3,     1'b0, 1'b0, '0,        '0,             1'b0},
    '{16'sd5,      16'sd7,      16'd1,     1'b1, 1'b0, '0,        '0,             1'b0},
    '{ELEM_MAX,    ELEM_MIN,    16'd4096,  1'b1, 1'b1, 23'd4194240,
      46'd17591649177600, 1'b0},
    '{-16'sd12345, 16'sd20000,  16'd5000,  1'b0, 1'b0, '0,        '0,             1'b0},
    '{16'sd7,      -16'sd7,     16'd1,     1'b1, 1'b0, '0,        '0,             1'b0},
    '{ELEM_MAX,    ELEM_MIN,    16'd16384, 1'b0, 1'b0, '0,        '0,             1'b0},
    '{ELEM_MAX,    -16'sd13573, 16'd1,     1'b0, 1'b0, '0,        '0,             1'b0},
    '{16'sd267,    16'sd0,      16'd1,     1'b0, 1'b0, '0,        '0,             1'b0},
    '{16'sd19,     16'sd0,      16'd1,     1'b0, 1'b0, '0,        '0,             1'b0},
    '{16'sd3,      16'sd0,      16'd1,     1'b0, 1'b0, '0,        '0,             1'b0},
    '{16'sd2,      16'sd0,      16'd1,     1'b1, 1'b1, ROOT_CEILING, SUM_CEILING, 1'b0},
    '{ELEM_MIN,    ELEM_MAX,    16'd16385, 1'b0, 1'b0, '0,        '0,             1'b0},
    '{ELEM_MAX,    ELEM_MIN,    16'd50,    1'b0, 1'b0, '0,        '0,             1'b0},
    '{16'sd0,      16'sd0,      16'd1,     1'b1, 1'b1, ROOT_CEILING, SUM_CEILING, 1'b1},
    '{16'sd0,      -16'sd1,     16'd1,     1'b1, 1'b1, 23'd1,     46'd1,          1'b0},
    '{-16'sd1,     16'sd0,      16'd2,     1'b1, 1'b0, '0,        '0,             1'b0}
  };

  euclidean_distance dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .elem_a      (elem_a),
    .elem_b      (elem_b),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .distance    (distance),
    .sum_squares (sum_squares),
    .overflowed  (overflowed)
  );

  // Clock and a single reset pulse at the start of the run.
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Floor square root, built up one bit of the root at a time.
  function automatic logic [DIST_W-1:0] floor_root(input logic [ACC_W-1:0] value);
    logic [DIST_W-1:0] root;
    logic [DIST_W-1:0] trial;
    longint unsigned   wide;
    root = '0;
    for (int i = DIST_W - 1; i >= 0; i--) begin
      trial = root | (23'd1 << i);
      wide  = trial;
      if (wide * wide <= value) root = trial;
    end
    return root;
  endfunction

  // Adds one squared difference to the model and, on the last pair,
  // gives the vector result and clears the sum and flag.
  task automatic accumulate_pair(input logic signed [ELEM_W-1:0] a,
                                 input logic signed [ELEM_W-1:0] b,
                                 input logic fin,
                                 output bit produced,
                                 output dist_result_t res);
    int              diff;
    longint unsigned square;
    diff = int'(a) - int'(b);
    if (diff < 0) diff = -diff;
    square = longint'(diff) * longint'(diff);
    if (sum_model > SUM_CEILING - square) begin
      sum_model       = SUM_CEILING;
      saturated_model = 1'b1;
    end else begin
      sum_model = sum_model + square[ACC_W-1:0];
    end
    produced = fin;
    res      = '0;
    if (fin) begin
      res.distance    = floor_root(sum_model);
      res.sum_squares = sum_model;
      res.overflowed  = saturated_model;
      sum_model       = '0;
      saturated_model = 1'b0;
    end
  endtask

  // Sender gap: mostly none, sometimes short, now and then long.
  function automatic int sender_gap();
    int pick;
    if (quiet_mode) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Drives one pair and waits for its transfer, then books the expectation.
  task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                           input logic signed [ELEM_W-1:0] b,
                           input logic fin,
                           input bit typed,
                           input dist_result_t typed_res);
    int           gap;
    bit           produced;
    dist_result_t res;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    elem_a   <= a;
    elem_b   <= b;
    last     <= fin;
    do @(posedge clk); while (!in_ready);
    accumulate_pair(a, b, fin, produced, res);
    if (produced) pending_results.push_back(typed ? typed_res : res);
  endtask

  // Random element in one of three styles: any value, an extreme, or small.
  function automatic logic signed [ELEM_W-1:0] random_elem(input int style);
    case (style)
      1: begin
        case ($urandom_range(0, 4))
          0: return ELEM_MIN;
          1: return ELEM_MAX;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      2: return 16'(int'($urandom_range(0, 510)) - 255);
      default: return 16'($urandom);
    endcase
  endfunction

  // Stimulus: the directed table, then random vectors.
  initial begin
    dist_result_t typed_res;
    int           sent;
    int           len;
    int           style;
    int           pick;
    wait (!rst);
    @(posedge clk);
    foreach (directed_rows[r]) begin
      typed_res.distance    = directed_rows[r].exp_distance;
      typed_res.sum_squares = directed_rows[r].exp_sum;
      typed_res.overflowed  = directed_rows[r].exp_flag;
      for (int k = 0; k < int'(directed_rows[r].reps); k++) begin
        send_pair(directed_rows[r].a, directed_rows[r].b,
                  directed_rows[r].fin && (k == int'(directed_rows[r].reps) - 1),
                  directed_rows[r].typed, typed_res);
      end
    end

    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      if ($urandom_range(0, 99) < 15) quiet_mode = ~quiet_mode;
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(1, 12);
      else if (pick < 95) len = $urandom_range(13, 200);
      else len = 1;
      style = $urandom_range(0, 2);
      for (int k = 0; k < len; k++) begin
        send_pair(random_elem(style), random_elem(style), k == len - 1, 1'b0, '0);
      end
      sent += len;
    end
    in_valid <= 1'b0;
    last     <= 1'b0;

    // Let every outstanding result arrive, then watch a little longer.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Receiver: runs of readiness, with stalls of random length between them.
  initial begin
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 80) repeat ($urandom_range(1, 8)) @(posedge clk);
      else repeat ($urandom_range(50, 200)) @(posedge clk);
      pick_stall : begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) stall = 0;
        else if (pick < 90) stall = $urandom_range(1, 4);
        else stall = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Result check: each output transfer against the oldest expectation.
  always @(posedge clk) begin
    dist_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: distance %0d sum_squares %0d overflowed %0b",
               distance, sum_squares, overflowed);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, distance);
          error_count++;
        end
        if (sum_squares !== want.sum_squares) begin
          $error("sum_squares: expected %0d, got %0d", want.sum_squares, sum_squares);
          error_count++;
        end
        if (overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, overflowed);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- euclidean_distance.f -----
+incdir+hw/rtl
hw/rtl/ed_pkg.sv
hw/rtl/ed_isqrt.sv
hw/rtl/ed_datapath.sv
hw/rtl/ed_ctrl.sv
hw/rtl/euclidean_distance.sv
test/testbench.sv
